[design/variable_record_ring_allocator_macros.svh]
`ifndef VARIABLE_RECORD_RING_ALLOCATOR_MACROS_SVH
`define VARIABLE_RECORD_RING_ALLOCATOR_MACROS_SVH

// condition holds at every edge outside reset
`define VRRA_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence holds in the same cycle
`define VRRA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the next cycle
`define VRRA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/vrra_pkg.sv]
`default_nettype none

package vrra_pkg;

   localparam int MAX_BUFFER_BYTES = 4096;
   localparam int MIN_BUFFER_BYTES = 16;
   localparam int HEADER_BYTES     = 8;
   localparam int ALIGN_MASK       = 3;
   localparam int ROUND_ADD        = HEADER_BYTES + ALIGN_MASK;

   localparam int ACT_W    = 2;
   localparam int STATUS_W = 3;
   localparam int OFS_W    = $clog2(MAX_BUFFER_BYTES);
   localparam int BYTES_W  = OFS_W + 1;
   localparam int SIZE_W   = 13;
   localparam int HDR_W    = SIZE_W + 1;
   localparam int ROUND_W  = BYTES_W + 1;
   localparam int CNT_W    = 10;

   localparam int STORE_DEPTH = MAX_BUFFER_BYTES / 4;
   localparam int SLOT_W      = $clog2(STORE_DEPTH);

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_COMMIT  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK              = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTHING_PENDING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HANDLE_MISMATCH = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_RECORDS      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TAG_MISSING     = 3'd5;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [BYTES_W-1:0] request_bytes;
      logic [OFS_W-1:0]   handle_offset;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [OFS_W-1:0]    payload_offset;
      logic [STATUS_W-1:0] status;
      logic                replaced_pending;
      logic                wrapped_to_start;
      logic [CNT_W-1:0]    records_held;
   } rsp_type;

   typedef struct packed {
      logic [OFS_W-1:0]  read_offset;
      logic [OFS_W-1:0]  write_offset;
      logic              pend_valid;
      logic [OFS_W-1:0]  pend_start;
      logic [OFS_W-1:0]  pend_end;
      logic              pend_tag;
      logic [SIZE_W-1:0] pend_size;
      logic [CNT_W-1:0]  record_count;
   } ring_state_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [HDR_W-1:0]  data;
   } mem_wr_type;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [OFS_W-1:0] ofs);
      return ofs[OFS_W-1:2];
   endfunction

   // header position for a release: jump to ring start when the handle points there
   function automatic logic [OFS_W-1:0] release_base(input logic [OFS_W-1:0] handle,
                                                    input logic [OFS_W-1:0] rd);
      logic [OFS_W-1:0] hpos;
      hpos = handle - OFS_W'(HEADER_BYTES);
      return (hpos != rd && hpos == '0) ? '0 : rd;
   endfunction

endpackage

`default_nettype wire

[design/vrra_if.sv]
`default_nettype none

interface vrra_req_if;
   import vrra_pkg::*;

   logic               valid;
   logic               ready;
   logic [ACT_W-1:0]   action;
   logic [BYTES_W-1:0] request_bytes;
   logic [OFS_W-1:0]   handle_offset;

   modport source (output valid, action, request_bytes, handle_offset, input ready);
   modport sink (input valid, action, request_bytes, handle_offset, output ready);
endinterface

interface vrra_rsp_if;
   import vrra_pkg::*;

   logic                valid;
   logic                ready;
   logic                ok;
   logic [OFS_W-1:0]    payload_offset;
   logic [STATUS_W-1:0] status;
   logic                replaced_pending;
   logic                wrapped_to_start;
   logic [CNT_W-1:0]    records_held;

   modport source (output valid, ok, payload_offset, status, replaced_pending,
                   wrapped_to_start, records_held, input ready);
   modport sink (input valid, ok, payload_offset, status, replaced_pending,
                 wrapped_to_start, records_held, output ready);
endinterface

`default_nettype wire

[design/variable_record_ring_allocator.sv]
// Ring allocator for variable-length records with an 8-byte header in front of each
// payload. A transaction is accepted into an input stage while the header memory is read
// at the release position; when the result register is free, the input stage applies the
// action to the offsets, the pending reservation and the record count, and loads the result
// register. One transaction can be accepted every cycle while the result is taken and no
// clearing runs; the synchronous read of the 1024-entry header memory is forwarded past
// the write of the transaction ahead. After reset and after every buffer_bytes write
// the header memory is cleared, one entry a cycle across all 1024 entries, and no request
// transaction is accepted in that time.
`default_nettype none
`include "variable_record_ring_allocator_macros.svh"

module variable_record_ring_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   vrra_req_if.sink                           req_chan,
   vrra_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_write_en,
   input  wire logic [vrra_pkg::BYTES_W-1:0]  csr_write_data
);
   import vrra_pkg::*;

   logic [BYTES_W-1:0] buffer_bytes_ff, buffer_bytes_in;
   logic [BYTES_W-1:0] csr_rounded;
   logic               clear_active_ff, clear_active_in;
   logic [SLOT_W-1:0]  clear_addr_ff, clear_addr_in;
   ring_state_type     ring_ff, ring_in, ring_calc;
   logic               a_valid_ff, a_valid_in;
   req_type            a_item_ff;
   logic               fwd_hit_ff;
   logic [HDR_W-1:0]   fwd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, exec_result;
   mem_wr_type         exec_wr, mem_wr;
   logic [SLOT_W-1:0]  rd_slot;
   logic [HDR_W-1:0]   ram_q;
   logic [HDR_W-1:0]   hdr_read;
   req_type            req_item;
   logic               req_fire;
   logic               out_free;
   logic               a_fire;

   assign req_item.action        = req_chan.action;
   assign req_item.request_bytes = req_chan.request_bytes;
   assign req_item.handle_offset = req_chan.handle_offset;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign a_fire         = a_valid_ff && out_free;
   assign req_chan.ready = !clear_active_ff && (!a_valid_ff || out_free);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // ring size register
   always_comb begin
      csr_rounded = {csr_write_data[BYTES_W-1:2], 2'b00};
      priority if (!csr_write_en) begin
         buffer_bytes_in = buffer_bytes_ff;
      end else if (csr_rounded < BYTES_W'(MIN_BUFFER_BYTES)) begin
         buffer_bytes_in = BYTES_W'(MIN_BUFFER_BYTES);
      end else if (csr_rounded > BYTES_W'(MAX_BUFFER_BYTES)) begin
         buffer_bytes_in = BYTES_W'(MAX_BUFFER_BYTES);
      end else begin
         buffer_bytes_in = csr_rounded;
      end
   end

   // header clearing sweep
   always_comb begin
      priority if (csr_write_en) begin
         clear_active_in = 1'b1;
         clear_addr_in   = '0;
      end else if (clear_active_ff) begin
         clear_addr_in   = clear_addr_ff + SLOT_W'(1);
         clear_active_in = (clear_addr_ff != '1);
      end else begin
         clear_active_in = clear_active_ff;
         clear_addr_in   = clear_addr_ff;
      end
   end

   vrra_exec u_exec (
      .item         (a_item_ff),
      .cur          (ring_ff),
      .buffer_bytes (buffer_bytes_ff),
      .mem_hdr      (hdr_read),
      .nxt          (ring_calc),
      .result       (exec_result),
      .mem_wr       (exec_wr)
   );

   always_comb begin
      priority if (csr_write_en) begin
         ring_in = '0;
      end else if (a_fire) begin
         ring_in = ring_calc;
      end else begin
         ring_in = ring_ff;
      end
   end

   always_comb begin
      priority if (clear_active_ff) begin
         mem_wr      = '0;
         mem_wr.en   = 1'b1;
         mem_wr.addr = clear_addr_ff;
      end else if (a_fire) begin
         mem_wr = exec_wr;
      end else begin
         mem_wr = '0;
      end
   end

   // header read is aimed at the ring state left by the transaction ahead
   assign rd_slot  = slot_of(release_base(req_chan.handle_offset, ring_in.read_offset));
   assign hdr_read = fwd_hit_ff ? fwd_data_ff : ram_q;

   vrra_ram #(
      .WIDTH (HDR_W),
      .DEPTH (STORE_DEPTH)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (req_fire),
      .rd_addr (rd_slot),
      .rd_data (ram_q)
   );

   always_comb begin
      priority if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (a_fire) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_comb begin
      priority if (a_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_bytes_ff <= BYTES_W'(MAX_BUFFER_BYTES);
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
         ring_ff         <= '0;
         a_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         buffer_bytes_ff <= buffer_bytes_in;
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
         ring_ff         <= ring_in;
         a_valid_ff      <= a_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_item_ff   <= req_item;
         fwd_hit_ff  <= mem_wr.en && (mem_wr.addr == rd_slot);
         fwd_data_ff <= mem_wr.data;
      end
      if (a_fire) begin
         rsp_data_ff <= exec_result;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.ok               = rsp_data_ff.ok;
   assign rsp_chan.payload_offset   = rsp_data_ff.payload_offset;
   assign rsp_chan.status           = rsp_data_ff.status;
   assign rsp_chan.replaced_pending = rsp_data_ff.replaced_pending;
   assign rsp_chan.wrapped_to_start = rsp_data_ff.wrapped_to_start;
   assign rsp_chan.records_held     = rsp_data_ff.records_held;

   `VRRA_ASSERT_NOW(a_read_in_ring, BYTES_W'(ring_ff.read_offset) < buffer_bytes_ff,
                    "read offset outside ring")
   `VRRA_ASSERT_NOW(a_write_in_ring, BYTES_W'(ring_ff.write_offset) < buffer_bytes_ff,
                    "write offset outside ring")
   `VRRA_ASSERT_NXT(a_accept_lands, req_fire, a_valid_ff,
                    "accepted transaction lost before execution")
   `VRRA_ASSERT_IMP(a_ok_status, rsp_valid_ff, rsp_data_ff.ok == (rsp_data_ff.status == ST_OK),
                    "ok and status disagree")

endmodule

`default_nettype wire

[design/vrra_ram.sv]
`default_nettype none

module vrra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/vrra_exec.sv]
`default_nettype none

module vrra_exec (
   input  wire vrra_pkg::req_type              item,
   input  wire vrra_pkg::ring_state_type       cur,
   input  wire logic [vrra_pkg::BYTES_W-1:0]   buffer_bytes,
   input  wire logic [vrra_pkg::HDR_W-1:0]     mem_hdr,
   output vrra_pkg::ring_state_type            nxt,
   output vrra_pkg::rsp_type                   result,
   output vrra_pkg::mem_wr_type                mem_wr
);
   import vrra_pkg::*;

   logic [ROUND_W-1:0] rsize;
   logic [BYTES_W-1:0] tail;
   logic               fits_tail;
   logic               fits_wrap;
   logic               fits_gap;
   logic               found;
   logic               at_start;
   logic [OFS_W-1:0]   start;
   logic [ROUND_W-1:0] end_sum;
   logic [OFS_W-1:0]   end_ofs;
   logic [OFS_W-1:0]   base;
   logic               pend_hit;
   logic [HDR_W-1:0]   hdr;
   logic [ROUND_W-1:0] nr_sum;
   logic [OFS_W-1:0]   nr_ofs;

   // reserve placement
   assign rsize = (ROUND_W'(item.request_bytes) + ROUND_W'(ROUND_ADD)) & ~ROUND_W'(ALIGN_MASK);
   assign tail  = (buffer_bytes > BYTES_W'(cur.write_offset))
                  ? buffer_bytes - BYTES_W'(cur.write_offset) : '0;
   assign fits_tail = (ROUND_W'(tail) > rsize)
                      || (ROUND_W'(tail) == rsize && cur.read_offset != '0);
   assign fits_wrap = ROUND_W'(cur.read_offset) > rsize;
   assign fits_gap  = ROUND_W'(cur.read_offset - cur.write_offset) > rsize;

   always_comb begin
      if (cur.write_offset >= cur.read_offset) begin
         found    = fits_tail || fits_wrap;
         at_start = !fits_tail && fits_wrap;
      end else begin
         found    = fits_gap;
         at_start = 1'b0;
      end
   end

   assign start   = at_start ? '0 : cur.write_offset;
   assign end_sum = ROUND_W'(start) + rsize;
   assign end_ofs = (end_sum == ROUND_W'(buffer_bytes)) ? '0 : end_sum[OFS_W-1:0];

   // release header, the pending record lives in registers until commit
   assign base     = release_base(item.handle_offset, cur.read_offset);
   assign pend_hit = cur.pend_valid && (slot_of(cur.pend_start) == slot_of(base));
   assign hdr      = pend_hit ? {cur.pend_tag, cur.pend_size} : mem_hdr;
   assign nr_sum   = ROUND_W'(base) + ROUND_W'(hdr[SIZE_W-1:0]);
   assign nr_ofs   = (nr_sum == ROUND_W'(buffer_bytes)) ? '0 : nr_sum[OFS_W-1:0];

   always_comb begin
      nxt    = cur;
      result = '0;
      mem_wr = '0;
      result.status = ST_OK;
      unique case (item.action)
         ACT_RESERVE: begin
            if (cur.pend_valid) begin
               result.replaced_pending = 1'b1;
               mem_wr.en   = 1'b1;
               mem_wr.addr = slot_of(cur.pend_start);
               mem_wr.data = '0;
            end
            nxt.pend_valid = found;
            if (found) begin
               nxt.pend_start = start;
               nxt.pend_end   = end_ofs;
               nxt.pend_tag   = 1'b1;
               nxt.pend_size  = rsize[SIZE_W-1:0];
               result.ok               = 1'b1;
               result.payload_offset   = start + OFS_W'(HEADER_BYTES);
               result.wrapped_to_start = at_start;
            end else begin
               result.status = ST_NO_SPACE;
            end
         end
         ACT_COMMIT: begin
            priority if (!cur.pend_valid) begin
               result.status = ST_NOTHING_PENDING;
            end else if (item.handle_offset != cur.pend_start + OFS_W'(HEADER_BYTES)) begin
               result.status = ST_HANDLE_MISMATCH;
            end else begin
               if (cur.record_count != CNT_MAX) begin
                  nxt.record_count = cur.record_count + CNT_W'(1);
               end
               nxt.write_offset = cur.pend_end;
               nxt.pend_valid   = 1'b0;
               result.ok        = 1'b1;
               mem_wr.en   = 1'b1;
               mem_wr.addr = slot_of(cur.pend_start);
               mem_wr.data = {cur.pend_tag, cur.pend_size};
            end
         end
         ACT_RELEASE: begin
            if (cur.record_count == '0) begin
               result.status = ST_NO_RECORDS;
            end else begin
               nxt.read_offset         = base;
               result.wrapped_to_start = (base != cur.read_offset);
               if (hdr[HDR_W-1]) begin
                  nxt.read_offset  = nr_ofs;
                  nxt.record_count = cur.record_count - CNT_W'(1);
                  result.ok        = 1'b1;
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = slot_of(base);
                  mem_wr.data = '0;
                  if (pend_hit) begin
                     nxt.pend_tag = 1'b0;
                  end
               end else begin
                  result.status = ST_TAG_MISSING;
               end
            end
         end
         default: begin
            result.status = ST_NOTHING_PENDING;
         end
      endcase
      result.records_held = nxt.record_count;
   end

endmodule

`default_nettype wire
